/* rtl/core/ffp_pkg.sv */
`timescale 1ns / 1ps

package ffp_pkg;

	// Default frame geometry.
	localparam int unsigned FRAME_WIDTH_DEF  = 512;
	localparam int unsigned FRAME_HEIGHT_DEF = 320;

	// Configuration register file.
	localparam int unsigned APB_DW        = 32;
	localparam int unsigned PADDR_W       = 3;
	localparam int unsigned REG_HOT_VALUE = 0;
	localparam logic [7:0]  HOT_RESET     = 8'(255 - 17);

	// Request opcodes carried in tuser.
	localparam logic [1:0] FUNC_SEED = 2'd0;
	localparam logic [1:0] FUNC_RUN  = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	// Stream payload widths.
	localparam int unsigned IN_DW   = 24;
	localparam int unsigned IN_UW   = 2;
	localparam int unsigned OUT_DW  = 24;
	localparam int unsigned ROWS_W  = 9;

	// Edge columns divide by three: floor(s * 683 / 2048) is exact for s <= 765.
	localparam int unsigned DIV3_MUL   = 683;
	localparam int unsigned DIV3_SHIFT = 11;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_step;
		logic capture;
		logic seed_wr;
		logic rd_addr;
		logic rd_issue;
		logic sweep_init;
		logic issue;
		logic row_next;
		logic resp_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       clr_last;
		logic       issue_last;
		logic       pipe_busy;
		logic       decayed;
		logic       top_row;
		logic       out_free;
		logic [1:0] func;
	} stat_t;

endpackage

/* rtl/core/ffp_ctrl.sv */
`timescale 1ns / 1ps

module ffp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ffp_pkg::stat_t stat,
	output ffp_pkg::cmd_t  cmd
);

	typedef enum logic [7:0] {
		ST_CLEAR    = 8'b0000_0001,
		ST_IDLE     = 8'b0000_0010,
		ST_DISPATCH = 8'b0000_0100,
		ST_READ     = 8'b0000_1000,
		ST_ROW      = 8'b0001_0000,
		ST_DRAIN    = 8'b0010_0000,
		ST_ROW_END  = 8'b0100_0000,
		ST_RESP     = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (stat.func)
					ffp_pkg::FUNC_SEED: begin
						cmd.seed_wr = 1'b1;
						state_d     = ST_RESP;
					end
					ffp_pkg::FUNC_RUN: begin
						cmd.sweep_init = 1'b1;
						state_d        = ST_ROW;
					end
					ffp_pkg::FUNC_READ: begin
						cmd.rd_addr = 1'b1;
						state_d     = ST_READ;
					end
					default: begin
						state_d = ST_RESP;
					end
				endcase
			end
			ST_READ: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_RESP;
			end
			ST_ROW: begin
				cmd.issue = 1'b1;
				if (stat.issue_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_d = ST_ROW_END;
				end
			end
			ST_ROW_END: begin
				cmd.row_next = 1'b1;
				if (!stat.decayed || stat.top_row) begin
					state_d = ST_RESP;
				end else begin
					state_d = ST_ROW;
				end
			end
			ST_RESP: begin
				if (stat.out_free) begin
					cmd.resp_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register; the clearing pass runs first after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/core/ffp_datapath.sv */
`timescale 1ns / 1ps

module ffp_datapath #(
	parameter int unsigned FRAME_WIDTH  = ffp_pkg::FRAME_WIDTH_DEF,
	parameter int unsigned FRAME_HEIGHT = ffp_pkg::FRAME_HEIGHT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ffp_pkg::cmd_t               cmd,
	output ffp_pkg::stat_t              stat,
	input  logic [ffp_pkg::IN_DW-1:0]   in_data,
	input  logic [ffp_pkg::IN_UW-1:0]   in_user,
	input  logic [7:0]                  hot_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ffp_pkg::OUT_DW-1:0]  out_data
);

	localparam int unsigned DEPTH     = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int unsigned AW        = $clog2(DEPTH);
	localparam int unsigned XW        = $clog2(FRAME_WIDTH + 1);
	localparam int unsigned RW        = $clog2(FRAME_HEIGHT);
	localparam int unsigned LAST_BASE = (FRAME_HEIGHT - 1) * FRAME_WIDTH;

	// Frame store, row-major, one write and two reads per cycle.
	logic [7:0] mem [DEPTH];

	// Captured request.
	logic [1:0]    func_q;
	logic [8:0]    x_q;
	logic [8:0]    y_q;
	logic          bit_q;
	logic [AW-1:0] rd_addr_q;
	logic          rd_ok_q;

	// Clearing pass and sweep bookkeeping.
	logic [AW-1:0] clr_q;
	logic [RW-1:0] row_q;
	logic [RW-1:0] cnt_q;
	logic [AW-1:0] base_q;
	logic [XW-1:0] j_q;
	logic          decayed_q;

	// Pixel pipeline.
	logic          vld_s1;
	logic [XW-1:0] j_s1;
	logic [7:0]    cur_s1;
	logic [7:0]    up_s1;
	logic [7:0]    hold_l_q;
	logic [7:0]    hold_c_q;
	logic [7:0]    hold_u_q;
	logic          vld_s2;
	logic [AW-1:0] wa_s2;
	logic [9:0]    sum_s2;
	logic          edge_s2;

	// Result register.
	logic          out_valid_q;
	logic [7:0]    pix_q;
	logic [8:0]    rows_q;

	logic [AW-1:0] up_base;
	logic [AW-1:0] ra;
	logic [AW-1:0] rb;
	logic          re_a;
	logic          re_b;
	logic          we;
	logic [AW-1:0] wa;
	logic [7:0]    wd;
	logic          left_edge;
	logic          right_edge;
	logic [9:0]    sum_d;
	logic [19:0]   prod;
	logic [7:0]    quot;
	logic          dec;
	logic [7:0]    new_pix;

	assign up_base = base_q - AW'(FRAME_WIDTH);

	// Status toward the controller.
	assign stat.clr_last   = (clr_q == AW'(DEPTH - 1));
	assign stat.issue_last = (j_q == XW'(FRAME_WIDTH));
	assign stat.pipe_busy  = vld_s1 | vld_s2;
	assign stat.decayed    = decayed_q;
	assign stat.top_row    = (row_q == RW'(1));
	assign stat.out_free   = !out_valid_q || out_ready;
	assign stat.func       = func_q;

	// Read ports: port A serves the current row and single pixel reads, port B the row above.
	always_comb begin
		re_a = 1'b0;
		re_b = 1'b0;
		ra   = base_q + AW'(j_q);
		rb   = up_base + AW'(j_q);
		if (cmd.rd_issue) begin
			re_a = rd_ok_q;
			ra   = rd_addr_q;
		end else if (cmd.issue && (j_q != XW'(FRAME_WIDTH))) begin
			re_a = 1'b1;
			re_b = 1'b1;
		end
	end

	// Write port: clearing pass, seed pixel or a finished sweep pixel.
	always_comb begin
		we = 1'b0;
		wa = wa_s2;
		wd = new_pix;
		if (cmd.clr_step) begin
			we = 1'b1;
			wa = clr_q;
			wd = '0;
		end else if (cmd.seed_wr) begin
			we = (32'(x_q) < FRAME_WIDTH);
			wa = AW'(LAST_BASE) + AW'(x_q);
			wd = bit_q ? hot_value : 8'd0;
		end else begin
			we = vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re_a) begin
			cur_s1 <= mem[ra];
		end
		if (re_b) begin
			up_s1 <= mem[rb];
		end
	end

	// Window sum for pixel j_s1-1; the edge columns drop the missing neighbor.
	always_comb begin
		left_edge  = (j_s1 == XW'(1));
		right_edge = (j_s1 == XW'(FRAME_WIDTH));
		if (right_edge) begin
			sum_d = 10'(hold_c_q) + 10'(hold_l_q) + 10'(hold_u_q);
		end else if (left_edge) begin
			sum_d = 10'(hold_c_q) + 10'(cur_s1) + 10'(hold_u_q);
		end else begin
			sum_d = 10'(hold_l_q) + 10'(hold_c_q) + 10'(cur_s1) + 10'(hold_u_q);
		end
	end

	// Divide, then decay by one where the value exceeds one.
	always_comb begin
		prod    = 20'(sum_s2) * 20'(ffp_pkg::DIV3_MUL);
		quot    = edge_s2 ? prod[ffp_pkg::DIV3_SHIFT +: 8] : sum_s2[9:2];
		dec     = (quot > 8'd1);
		new_pix = dec ? (quot - 8'd1) : quot;
	end

	// Payload registers of the request, of the pixel pipeline and of the result.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= in_user;
			x_q    <= in_data[8:0];
			y_q    <= in_data[17:9];
			bit_q  <= in_data[18];
		end
		if (cmd.rd_addr) begin
			rd_addr_q <= AW'(32'(y_q) * FRAME_WIDTH + 32'(x_q));
			rd_ok_q   <= (32'(x_q) < FRAME_WIDTH) && (32'(y_q) < FRAME_HEIGHT);
		end
		j_s1 <= j_q;
		if (vld_s1 && !right_edge) begin
			hold_l_q <= hold_c_q;
			hold_c_q <= cur_s1;
			hold_u_q <= up_s1;
		end
		wa_s2   <= up_base + AW'(j_s1 - XW'(1));
		sum_s2  <= sum_d;
		edge_s2 <= left_edge || right_edge;
		if (cmd.resp_load) begin
			pix_q  <= ((func_q == ffp_pkg::FUNC_READ) && rd_ok_q) ? cur_s1 : 8'd0;
			rows_q <= (func_q == ffp_pkg::FUNC_RUN) ? 9'(cnt_q) : 9'd0;
		end
	end

	// Control registers: counters, pipeline valids and the result flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			row_q       <= '0;
			cnt_q       <= '0;
			base_q      <= '0;
			j_q         <= '0;
			decayed_q   <= 1'b0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1 && (j_s1 != '0);
			if (cmd.sweep_init) begin
				row_q     <= RW'(FRAME_HEIGHT - 1);
				cnt_q     <= '0;
				base_q    <= AW'(LAST_BASE);
				j_q       <= '0;
				decayed_q <= 1'b0;
			end else if (cmd.row_next) begin
				row_q     <= row_q - RW'(1);
				cnt_q     <= cnt_q + RW'(1);
				base_q    <= up_base;
				j_q       <= '0;
				decayed_q <= 1'b0;
			end else begin
				if (cmd.issue) begin
					j_q <= j_q + XW'(1);
				end
				if (vld_s2 && dec) begin
					decayed_q <= 1'b1;
				end
			end
			if (cmd.resp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {(ffp_pkg::OUT_DW - 17)'(0), rows_q, pix_q};

endmodule

/* rtl/core/fire_frame_propagation.sv */
`timescale 1ns / 1ps

// Channel   Direction  Signals                        Carries
// s_axis    in         tvalid tready tdata tuser      one request: opcode, column, row, seed
// m_axis    out        tvalid tready tdata            one result per request
// apb       in/out     psel penable pwrite paddr ...  hot_value register at byte address 0
//
// From acceptance to the result register a seed request passes ST_DISPATCH and ST_RESP,
// a read ST_DISPATCH, ST_READ and ST_RESP. A sweep issues one pixel per cycle in each row,
// then drains the pipeline. After reset a clearing pass writes zero to every pixel
// while s_axis_tready stays low.
// A new request is taken while the previous result waits; its own result waits for the
// result register to be freed by m_axis_tready.
module fire_frame_propagation #(
	parameter int unsigned FRAME_WIDTH  = ffp_pkg::FRAME_WIDTH_DEF,
	parameter int unsigned FRAME_HEIGHT = ffp_pkg::FRAME_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// x_pos [8:0], y_pos [17:9], seed_bit [18], zero fill [23:19]
	input  logic [ffp_pkg::IN_DW-1:0]     s_axis_tdata,
	// func [1:0]
	input  logic [ffp_pkg::IN_UW-1:0]     s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// pixel_value [7:0], rows_done [16:8], zero fill [23:17]
	output logic [ffp_pkg::OUT_DW-1:0]    m_axis_tdata,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ffp_pkg::PADDR_W-1:0]   paddr,
	input  logic [ffp_pkg::APB_DW-1:0]    pwdata,
	output logic [ffp_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);

	ffp_pkg::cmd_t  cmd;
	ffp_pkg::stat_t stat;
	logic [7:0]     hot_value_q;
	logic           hot_sel;

	// Register decode on the word index of the address.
	assign pready  = 1'b1;
	assign hot_sel = (paddr[ffp_pkg::PADDR_W-1:2] ==
		(ffp_pkg::PADDR_W - 2)'(ffp_pkg::REG_HOT_VALUE));
	assign prdata  = hot_sel ? ffp_pkg::APB_DW'(hot_value_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hot_value_q <= ffp_pkg::HOT_RESET;
		end else if (psel && penable && pwrite && pready && hot_sel) begin
			hot_value_q <= pwdata[7:0];
		end
	end

	ffp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ffp_datapath #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.hot_value (hot_value_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

`ifndef SYNTHESIS
	// Only one request is in flight: acceptance drops ready.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while another is in flight");

	// A sweep never rewrites more rows than lie above the bottom row.
	a_rows_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (FRAME_HEIGHT > 512) ||
			(32'(m_axis_tdata[16:8]) < FRAME_HEIGHT))
		else $error("rows_done beyond frame height");

	// A result is either a pixel read or a sweep count, never both.
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[16:8] != 9'd0) |-> (m_axis_tdata[7:0] == 8'd0))
		else $error("result carries both a pixel and a row count");
`endif

endmodule

/* verif/fire_frame_propagation_tb.sv */
`timescale 1ns / 1ps

module fire_frame_propagation_tb;

	// The frame geometry follows the package defaults.
	localparam int unsigned FW = ffp_pkg::FRAME_WIDTH_DEF;
	localparam int unsigned FH = ffp_pkg::FRAME_HEIGHT_DEF;

	localparam logic [1:0] FUNC_SPARE = 2'd3;
	localparam logic [ffp_pkg::PADDR_W-1:0] HOT_ADDR =
		ffp_pkg::PADDR_W'(ffp_pkg::REG_HOT_VALUE * 4);
	localparam logic [ffp_pkg::PADDR_W-1:0] SPARE_ADDR = ffp_pkg::PADDR_W'(4);
	localparam int unsigned SWEEP_CYCLES    = 3 + (FH - 1) * (FW + 5);
	localparam int unsigned STALL_CYCLES    = 300;
	localparam int unsigned PHASE_FRAMES    = 5;
	localparam int unsigned SEEDS_PER_FRAME = 38;

	typedef struct packed {
		logic [1:0] func;
		logic [8:0] x_pos;
		logic [8:0] y_pos;
		logic       seed_bit;
	} fire_req_t;

	typedef struct packed {
		logic [7:0] pixel_value;
		logic [8:0] rows_done;
	} fire_res_t;

	logic                             clk;
	logic                             arst_n;
	logic                             s_axis_tvalid;
	logic                             s_axis_tready;
	// x_pos [8:0], y_pos [17:9], seed_bit [18], zero fill [23:19]
	logic [ffp_pkg::IN_DW-1:0]        s_axis_tdata;
	// func [1:0]
	logic [ffp_pkg::IN_UW-1:0]        s_axis_tuser;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready;
	// pixel_value [7:0], rows_done [16:8], zero fill [23:17]
	logic [ffp_pkg::OUT_DW-1:0]       m_axis_tdata;
	logic                             psel;
	logic                             penable;
	logic                             pwrite;
	logic [ffp_pkg::PADDR_W-1:0]      paddr;
	logic [ffp_pkg::APB_DW-1:0]       pwdata;
	logic [ffp_pkg::APB_DW-1:0]       prdata;
	logic                             pready;

	// Shadow of the frame store and the register, plus the traffic queues.
	logic [7:0]   frame_model [FH][FW];
	logic [7:0]   hot_model;
	fire_req_t    req_queue [$];
	fire_res_t    result_queue [$];
	fire_req_t    drv_req;
	fire_res_t    oldest_result;
	int unsigned  send_idle_pct;
	int unsigned  recv_idle_pct;
	int unsigned  fail_count;
	logic         stall_req;
	logic         stall_seen;
	int unsigned  stall_left;

	fire_frame_propagation #(
		.FRAME_WIDTH (FW),
		.FRAME_HEIGHT(FH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Rewrites row y-1 from row y in place and reports whether any pixel cooled down.
	function automatic logic propagate_row(int unsigned y);
		int unsigned heat;
		logic        cooled;
		cooled = 1'b0;
		for (int unsigned x = 0; x < FW; x++) begin
			if (x == 0) begin
				heat = (frame_model[y][0] + frame_model[y][1] + frame_model[y-1][0]) / 3;
			end else if (x == FW - 1) begin
				heat = (frame_model[y][x] + frame_model[y][x-1] + frame_model[y-1][x]) / 3;
			end else begin
				heat = (frame_model[y][x] + frame_model[y][x+1] + frame_model[y][x-1]
					+ frame_model[y-1][x]) >> 2;
			end
			if (heat > 1) begin
				heat--;
				cooled = 1'b1;
			end
			frame_model[y-1][x] = heat[7:0];
		end
		return cooled;
	endfunction

	// Applies one request to the shadow frame and returns the result it should produce.
	function automatic fire_res_t compute_result(fire_req_t req);
		fire_res_t   res;
		int unsigned row;
		int unsigned count;
		logic        more;
		res = '0;
		case (req.func)
			ffp_pkg::FUNC_SEED: begin
				if (req.x_pos < FW)
					frame_model[FH-1][req.x_pos] = req.seed_bit ? hot_model : 8'd0;
			end
			ffp_pkg::FUNC_RUN: begin
				row = FH - 1;
				count = 0;
				more = 1'b1;
				while (more && row > 0) begin
					more = propagate_row(row);
					count++;
					row--;
				end
				res.rows_done = count[8:0];
			end
			ffp_pkg::FUNC_READ: begin
				if (req.x_pos < FW && req.y_pos < FH)
					res.pixel_value = frame_model[req.y_pos][req.x_pos];
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic fire_req_t random_req();
		fire_req_t r;
		r.func = 2'($urandom_range(3));
		r.x_pos = 9'($urandom_range(FW - 1));
		r.y_pos = 9'($urandom_range(FH - 1));
		r.seed_bit = 1'($urandom_range(1));
		return r;
	endfunction

	function automatic void push_req(logic [1:0] func, int unsigned x, int unsigned y, logic bit_v);
		fire_req_t r;
		r.func = func;
		r.x_pos = x[8:0];
		r.y_pos = y[8:0];
		r.seed_bit = bit_v;
		req_queue.push_back(r);
	endfunction

	// Request driver: the prediction is made at the edge that accepts the request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				result_queue.push_back(compute_result(drv_req));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_req = req_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= ffp_pkg::IN_DW'({drv_req.seed_bit, drv_req.y_pos,
						drv_req.x_pos});
					s_axis_tuser <= drv_req.func;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, started once each time the stall request goes high.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_left <= 0;
			stall_seen <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (stall_req && !stall_seen) begin
			stall_left <= STALL_CYCLES;
			stall_seen <= 1'b1;
		end else if (!stall_req) begin
			stall_seen <= 1'b0;
		end
	end

	// Result monitor: each result is compared with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (result_queue.size() == 0) begin
					$error("unexpected result: tdata %h", m_axis_tdata);
					fail_count++;
				end else begin
					oldest_result = result_queue.pop_front();
					if (m_axis_tdata[7:0] !== oldest_result.pixel_value) begin
						$error("pixel_value: expected %0d, got %0d",
							oldest_result.pixel_value, m_axis_tdata[7:0]);
						fail_count++;
					end
					if (m_axis_tdata[16:8] !== oldest_result.rows_done) begin
						$error("rows_done: expected %0d, got %0d",
							oldest_result.rows_done, m_axis_tdata[16:8]);
						fail_count++;
					end
				end
			end
			m_axis_tready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic apb_access(input logic wr, input logic [ffp_pkg::PADDR_W-1:0] addr,
		input logic [ffp_pkg::APB_DW-1:0] wdata, output logic [ffp_pkg::APB_DW-1:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_hot_readback();
		logic [ffp_pkg::APB_DW-1:0] rd;
		apb_access(1'b0, HOT_ADDR, '0, rd);
		if (rd !== ffp_pkg::APB_DW'(hot_model)) begin
			$error("hot_value readback: expected %0d, got %0d", hot_model, rd);
			fail_count++;
		end
	endtask

	// Upper write data bits are random; only the low byte is kept by the register.
	task automatic set_hot(input logic [7:0] value);
		logic [ffp_pkg::APB_DW-1:0] rd;
		apb_access(1'b1, HOT_ADDR, (ffp_pkg::APB_DW'($urandom()) &
			~ffp_pkg::APB_DW'(8'hFF)) | ffp_pkg::APB_DW'(value), rd);
		hot_model = value;
		check_hot_readback();
	endtask

	// A frame seeds random bottom-row columns, runs a sweep or two, reads pixels back and adds up to two random requests.
	task automatic queue_frames(input int unsigned frames);
		fire_req_t   r;
		int unsigned hot_pct;
		repeat (frames) begin
			hot_pct = $urandom_range(100);
			repeat (SEEDS_PER_FRAME) begin
				r = random_req();
				r.func = ffp_pkg::FUNC_SEED;
				r.seed_bit = $urandom_range(99) < hot_pct;
				req_queue.push_back(r);
			end
			repeat ($urandom_range(2, 1)) begin
				r = random_req();
				r.func = ffp_pkg::FUNC_RUN;
				req_queue.push_back(r);
			end
			repeat ($urandom_range(10, 4)) begin
				r = random_req();
				r.func = ffp_pkg::FUNC_READ;
				if ($urandom_range(4) != 0)
					r.y_pos = 9'(FH - 1 - $urandom_range(31));
				req_queue.push_back(r);
			end
			repeat ($urandom_range(2))
				req_queue.push_back(random_req());
		end
	endtask

	// Waits until every request is sent and every predicted result has arrived.
	task automatic wait_drained();
		while (req_queue.size() != 0 || s_axis_tvalid || result_queue.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		#1_500_000_000;
		$display("fire_frame_propagation regression: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		stall_req = 1'b0;
		fail_count = 0;
		send_idle_pct = 31;
		recv_idle_pct = 52;
		hot_model = ffp_pkg::HOT_RESET;
		for (int unsigned y = 0; y < FH; y++)
			for (int unsigned x = 0; x < FW; x++)
				frame_model[y][x] = 8'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		check_hot_readback();

		// Directed: empty and out-of-range reads, edge seeds, zero seeds, sweeps, the spare code.
		push_req(ffp_pkg::FUNC_READ, 0, FH - 1, 1'b0);
		push_req(ffp_pkg::FUNC_READ, 511, 319, 1'b1);
		push_req(ffp_pkg::FUNC_READ, FW - 1, 511, 1'b0);
		push_req(ffp_pkg::FUNC_READ, 0, FH, 1'b0);
		push_req(ffp_pkg::FUNC_SEED, 0, 0, 1'b1);
		push_req(ffp_pkg::FUNC_SEED, FW - 1, 0, 1'b1);
		push_req(ffp_pkg::FUNC_SEED, 7, 0, 1'b1);
		push_req(ffp_pkg::FUNC_SEED, 8, 319, 1'b0);
		push_req(ffp_pkg::FUNC_SEED, FW - 2, 0, 1'b1);
		push_req(ffp_pkg::FUNC_SEED, 511, 0, 1'b1);
		push_req(ffp_pkg::FUNC_READ, 0, FH - 1, 1'b0);
		push_req(ffp_pkg::FUNC_READ, FW - 1, FH - 1, 1'b0);
		push_req(ffp_pkg::FUNC_READ, 8, FH - 1, 1'b0);
		push_req(FUNC_SPARE, 511, 319, 1'b1);
		push_req(ffp_pkg::FUNC_RUN, 0, 0, 1'b0);
		push_req(ffp_pkg::FUNC_READ, 0, FH - 2, 1'b0);
		push_req(ffp_pkg::FUNC_READ, FW - 1, FH - 2, 1'b0);
		push_req(ffp_pkg::FUNC_RUN, 511, 319, 1'b1);
		push_req(ffp_pkg::FUNC_READ, 7, 0, 1'b0);
		push_req(ffp_pkg::FUNC_RUN, 0, 0, 1'b0);
		push_req(ffp_pkg::FUNC_READ, FW - 1, 0, 1'b1);
		push_req(FUNC_SPARE, 0, 0, 1'b0);
		wait_drained();

		// Largest hot value; a write to the unused address must leave it alone.
		set_hot(8'd255);
		begin
			logic [ffp_pkg::APB_DW-1:0] rd;
			apb_access(1'b1, SPARE_ADDR, ffp_pkg::APB_DW'($urandom()), rd);
		end
		check_hot_readback();
		queue_frames(PHASE_FRAMES);
		wait_drained();

		// The receiver now idles less often than the sender.
		set_hot(8'd0);
		send_idle_pct = 52;
		recv_idle_pct = 31;
		queue_frames(PHASE_FRAMES);
		wait_drained();

		set_hot(8'd1);
		queue_frames(PHASE_FRAMES);
		wait_drained();

		// No idling, and one long receiver stall so that the input backs up.
		set_hot(8'($urandom_range(255)));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_req = 1'b1;
		queue_frames(PHASE_FRAMES);
		wait_drained();
		stall_req = 1'b0;

		set_hot(ffp_pkg::HOT_RESET);
		queue_frames(PHASE_FRAMES);
		wait_drained();

		repeat (SWEEP_CYCLES + 16) @(posedge clk);
		if (result_queue.size() != 0) begin
			$error("%0d predicted results never arrived", result_queue.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("fire_frame_propagation regression: pass");
		else
			$display("fire_frame_propagation regression: fail");
		$finish;
	end

endmodule

/* files.f */
rtl/core/ffp_pkg.sv
rtl/core/ffp_ctrl.sv
rtl/core/ffp_datapath.sv
rtl/core/fire_frame_propagation.sv
verif/fire_frame_propagation_tb.sv
